// File: rtl/esq_pkg.sv
// ----------------------------------------------------------------------------
// esq_pkg
// Shared codes and constants for the end stop event qualifier.
// ----------------------------------------------------------------------------
package esq_pkg;

  // action codes of a result
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_STOP_MAX = 2'd1;
  localparam logic [1:0] ACT_STOP_MIN = 2'd2;
  localparam logic [1:0] ACT_STOPPED  = 2'd3;

  // request commands
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // query end select
  localparam logic [1:0] END_MIN = 2'd0;
  localparam logic [1:0] END_MAX = 2'd1;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [1:0] REG_INVERT_MASK = 2'd1;
  localparam logic [1:0] REG_MAX_MAP     = 2'd2;
  localparam logic [1:0] REG_MIN_MAP     = 2'd3;

  localparam logic [3:0]  NO_SWITCH       = 4'hf;
  localparam logic [31:0] RELEASE_HOLD_MS = 32'd5;
  localparam logic [7:0]  MASK_ALL        = 8'hff;

endpackage

// File: rtl/esq_ram.sv
// ----------------------------------------------------------------------------
// esq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module esq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/end_stop_event_qualifier_core.sv
// ----------------------------------------------------------------------------
// end_stop_event_qualifier_core
// Limit switch event qualification and end stop queries for a stepper
// controller.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready. A switch edge event (command 0)
// latches a press once per switch and returns the stop action; a query
// (command 1) returns whether the selected end stop of a stepper reads
// pressed; other end_select values read pressed. Each request yields exactly
// one result on out_valid/out_ready. A request and its deadline RAM read go
// into the qualify stage at acceptance, then into the output register;
// throughput is one request per cycle while results are taken. The RAM is
// written as a new press leaves the qualify stage, with a forward of the
// write that lands in the same cycle as the next read. When the receiver
// stalls, the output register and the qualify stage hold and in_ready drops
// once both are full. Reset (rst, synchronous) clears the press latches and
// restores the register defaults; deadlines are written before they are ever
// read, so the RAM needs no clearing pass. Configuration is written on
// cfg_we, by the user only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module end_stop_event_qualifier_core #(
  parameter int NUM_STEPPERS = 4,
  parameter int NUM_SWITCHES = 8
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [2:0]  switch_index,
  input  logic [1:0]  stepper_index,
  input  logic        event_level,
  input  logic        homing_active,
  input  logic [31:0] now_ms,
  input  logic [1:0]  end_select,
  input  logic [7:0]  switch_levels,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [1:0]  action_stepper,
  output logic        end_triggered
);

  // switch_index is three bits wide, so at most eight switches carry state
  localparam int SW_DEPTH = (NUM_SWITCHES < 8) ? NUM_SWITCHES : 8;
  localparam int IDX_W    = (SW_DEPTH > 1) ? $clog2(SW_DEPTH) : 1;

  // configuration
  logic [7:0]  enable_mask;
  logic [7:0]  invert_mask;
  logic [15:0] max_switch_map;
  logic [15:0] min_switch_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= 8'h00;
      invert_mask    <= esq_pkg::MASK_ALL;
      max_switch_map <= 16'hffff;
      min_switch_map <= 16'hffff;
    end else if (cfg_we) begin
      case (cfg_index)
        esq_pkg::REG_ENABLE_MASK: enable_mask    <= cfg_wdata[7:0];
        esq_pkg::REG_INVERT_MASK: invert_mask    <= cfg_wdata[7:0];
        esq_pkg::REG_MAX_MAP:     max_switch_map <= cfg_wdata;
        esq_pkg::REG_MIN_MAP:     min_switch_map <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // qualify stage
  logic             s1_valid;
  logic             s1_command;
  logic [2:0]       s1_sw;
  logic [1:0]       s1_stepper;
  logic             s1_level;
  logic             s1_homing;
  logic [31:0]      s1_now;
  logic [1:0]       s1_end_sel;
  logic [7:0]       s1_levels;
  logic             s1_fwd_hit;
  logic [31:0]      s1_fwd_data;

  logic [SW_DEPTH-1:0] latched;

  logic             in_fire;
  logic             s1_adv;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_data;
  logic [31:0]      ram_rdata;
  logic             clr_en;

  logic [1:0]       act_next;
  logic [1:0]       act_stepper_next;
  logic             trig_next;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  esq_ram #(
    .WIDTH (32),
    .DEPTH (SW_DEPTH)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (switch_index[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_command  <= command;
      s1_sw       <= switch_index;
      s1_stepper  <= stepper_index;
      s1_level    <= event_level;
      s1_homing   <= homing_active;
      s1_now      <= now_ms;
      s1_end_sel  <= end_select;
      s1_levels   <= switch_levels;
      // RAM read and write to the same entry at this edge: read sees old data
      s1_fwd_hit  <= wr_en && (wr_idx == switch_index[IDX_W-1:0]);
      s1_fwd_data <= wr_data;
    end
  end

  // qualify logic
  logic        sw_in_range;
  logic        sw_enabled;
  logic        pressed;
  logic        is_latched;
  logic [31:0] deadline;
  logic        stepper_ok;
  logic [3:0]  max_nib;
  logic [3:0]  min_nib;
  logic [3:0]  sel_nib;
  logic        set_latch;

  always_comb begin
    sw_in_range = 32'(s1_sw) < NUM_SWITCHES;
    sw_enabled  = sw_in_range && enable_mask[s1_sw];
    pressed     = s1_level ^ invert_mask[s1_sw];
    is_latched  = latched[s1_sw[IDX_W-1:0]];
    deadline    = s1_fwd_hit ? s1_fwd_data : ram_rdata;
    stepper_ok  = 32'(s1_stepper) < NUM_STEPPERS;
    max_nib     = stepper_ok ? max_switch_map[{s1_stepper, 2'b00} +: 4] : esq_pkg::NO_SWITCH;
    min_nib     = stepper_ok ? min_switch_map[{s1_stepper, 2'b00} +: 4] : esq_pkg::NO_SWITCH;
    sel_nib     = (s1_end_sel == esq_pkg::END_MAX) ? max_nib : min_nib;

    set_latch = 1'b0;
    clr_en    = 1'b0;
    act_next         = esq_pkg::ACT_NONE;
    act_stepper_next = 2'd0;
    trig_next        = 1'b0;

    if (s1_command == esq_pkg::CMD_EVENT) begin
      if (sw_enabled) begin
        if (pressed) begin
          if (!is_latched) begin
            set_latch = 1'b1;
            if (s1_homing && max_nib == {1'b0, s1_sw}) begin
              act_next         = esq_pkg::ACT_STOP_MAX;
              act_stepper_next = s1_stepper;
            end else if (s1_homing && min_nib == {1'b0, s1_sw}) begin
              act_next         = esq_pkg::ACT_STOP_MIN;
              act_stepper_next = s1_stepper;
            end else begin
              act_next = esq_pkg::ACT_STOPPED;
            end
          end
        end else if (is_latched && s1_now > deadline) begin
          clr_en = 1'b1;
        end
      end
    end else begin
      if (s1_end_sel == esq_pkg::END_MIN || s1_end_sel == esq_pkg::END_MAX) begin
        // an unmapped or missing switch reads not pressed
        if (32'(sel_nib) < NUM_SWITCHES && !sel_nib[3]) begin
          trig_next = s1_levels[sel_nib[2:0]] ^ invert_mask[sel_nib[2:0]];
        end
      end else begin
        trig_next = 1'b1;
      end
    end

    wr_en   = s1_adv && set_latch;
    wr_idx  = s1_sw[IDX_W-1:0];
    wr_data = s1_now + esq_pkg::RELEASE_HOLD_MS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched <= '0;
    end else if (s1_adv) begin
      if (set_latch) begin
        latched[s1_sw[IDX_W-1:0]] <= 1'b1;
      end else if (clr_en) begin
        latched[s1_sw[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      action         <= act_next;
      action_stepper <= act_stepper_next;
      end_triggered  <= trig_next;
    end
  end

  // checks
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("in_ready low while a stage is free");

  a_latch_gives_action: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && set_latch) |-> (act_next != esq_pkg::ACT_NONE))
    else $error("new press latched without a stop action");

  a_event_no_trigger: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_command == esq_pkg::CMD_EVENT) |=> (out_valid && !end_triggered))
    else $error("event result carries a query answer");

  a_stepper_only_on_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == esq_pkg::ACT_NONE || action == esq_pkg::ACT_STOPPED))
      |-> (action_stepper == 2'd0))
    else $error("stepper reported without a stop action");

  a_latch_set_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> latched[$past(wr_idx)])
    else $error("deadline written but latch not set");

endmodule

// File: test/esq_result_checker.sv
// ----------------------------------------------------------------------------
// esq_result_checker
// Watches the register port and both request/result channels of the end stop
// qualifier. It keeps its own copy of the registers, the press latches and
// the release deadlines, predicts the result of every accepted request, and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module esq_result_checker (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [2:0]  switch_index,
  input  logic [1:0]  stepper_index,
  input  logic        event_level,
  input  logic        homing_active,
  input  logic [31:0] now_ms,
  input  logic [1:0]  end_select,
  input  logic [7:0]  switch_levels,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  action_stepper,
  input  logic        end_triggered,

  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] stepper;
    logic       triggered;
  } stop_result_t;

  logic [7:0]   enable_bits;
  logic [7:0]   invert_bits;
  logic [15:0]  max_map;
  logic [15:0]  min_map;
  logic [7:0]   latched;
  logic [31:0]  deadline [8];
  stop_result_t expected_results [$];
  int           errors = 0;
  int           results_seen = 0;

  function automatic stop_result_t qualify_request(
    input logic        cmd,
    input logic [2:0]  sw,
    input logic [1:0]  stp,
    input logic        level,
    input logic        homing,
    input logic [31:0] now,
    input logic [1:0]  end_sel,
    input logic [7:0]  levels
  );
    stop_result_t r;
    logic [3:0]   max_sw;
    logic [3:0]   min_sw;
    logic [3:0]   mapped;
    r = '0;
    max_sw = max_map[stp*4 +: 4];
    min_sw = min_map[stp*4 +: 4];
    if (cmd == esq_pkg::CMD_EVENT) begin
      if (enable_bits[sw]) begin
        if (level ^ invert_bits[sw]) begin
          // only the first press of a latch reports; bounces are quiet
          if (!latched[sw]) begin
            latched[sw] = 1'b1;
            deadline[sw] = now + esq_pkg::RELEASE_HOLD_MS;
            if (homing && {1'b0, sw} == max_sw) begin
              r.action = esq_pkg::ACT_STOP_MAX;
              r.stepper = stp;
            end else if (homing && {1'b0, sw} == min_sw) begin
              r.action = esq_pkg::ACT_STOP_MIN;
              r.stepper = stp;
            end else begin
              r.action = esq_pkg::ACT_STOPPED;
            end
          end
        end else if (latched[sw] && now > deadline[sw]) begin
          // plain unsigned compare, a wrapped deadline releases early
          latched[sw] = 1'b0;
        end
      end
    end else if (end_sel == esq_pkg::END_MIN || end_sel == esq_pkg::END_MAX) begin
      mapped = (end_sel == esq_pkg::END_MAX) ? max_sw : min_sw;
      if (mapped != esq_pkg::NO_SWITCH && mapped < 4'd8)
        r.triggered = levels[mapped[2:0]] ^ invert_bits[mapped[2:0]];
    end else begin
      r.triggered = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stop_result_t got;
    stop_result_t want;
    if (rst) begin
      enable_bits = '0;
      invert_bits = esq_pkg::MASK_ALL;
      max_map = {4{esq_pkg::NO_SWITCH}};
      min_map = {4{esq_pkg::NO_SWITCH}};
      latched = '0;
      expected_results.delete();
    end else begin
      // retire results first: a result never belongs to a request taken
      // at the same edge
      if (out_valid && out_ready) begin
        got = {action, action_stepper, end_triggered};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] result with no request waiting: action %0d stepper %0d trig %0d",
                     $realtime, got.action, got.stepper, got.triggered);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("[%0t] mismatch: action %0d/%0d stepper %0d/%0d trig %0d/%0d (exp/got)",
                       $realtime, want.action, got.action, want.stepper, got.stepper,
                       want.triggered, got.triggered);
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(qualify_request(command, switch_index, stepper_index,
                                                   event_level, homing_active, now_ms,
                                                   end_select, switch_levels));
      if (cfg_we) begin
        case (cfg_index)
          esq_pkg::REG_ENABLE_MASK: enable_bits = cfg_wdata[7:0];
          esq_pkg::REG_INVERT_MASK: invert_bits = cfg_wdata[7:0];
          esq_pkg::REG_MAX_MAP:     max_map = cfg_wdata;
          esq_pkg::REG_MIN_MAP:     min_map = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending <= expected_results.size();
    checked <= results_seen;
  end

endmodule

// File: test/end_stop_event_qualifier_core_test.sv
// ----------------------------------------------------------------------------
// end_stop_event_qualifier_core_test
// Drives switch edge events and end stop queries into the qualifier through
// a sequence of register settings, with random gaps on both channels and one
// long output stall. Results are predicted and checked by esq_result_checker.
// ----------------------------------------------------------------------------
module end_stop_event_qualifier_core_test;

  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = esq_pkg::REG_ENABLE_MASK;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = esq_pkg::CMD_EVENT;
  logic [2:0]  switch_index = '0;
  logic [1:0]  stepper_index = '0;
  logic        event_level = 1'b0;
  logic        homing_active = 1'b0;
  logic [31:0] now_ms = '0;
  logic [1:0]  end_select = esq_pkg::END_MIN;
  logic [7:0]  switch_levels = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  action;
  logic [1:0]  action_stepper;
  logic        end_triggered;

  int          fail_count;
  int          pending;
  int          checked;

  int          send_gap_max = 7;
  int          take_gap_max = 7;
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;
  logic [31:0] clock_ms = '0;
  int          n_events = 0;
  int          n_queries = 0;
  int          n_settings = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  end_stop_event_qualifier_core dut (.*);

  esq_result_checker u_checker (.*);

  task automatic put_request(
    input logic        cmd,
    input logic [2:0]  sw,
    input logic [1:0]  stp,
    input logic        lvl,
    input logic        hom,
    input logic [31:0] now,
    input logic [1:0]  esel,
    input logic [7:0]  lv
  );
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    switch_index <= sw;
    stepper_index <= stp;
    event_level <= lvl;
    homing_active <= hom;
    now_ms <= now;
    end_select <= esel;
    switch_levels <= lv;
    if (cmd == esq_pkg::CMD_EVENT)
      n_events++;
    else
      n_queries++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(
    input logic [7:0]  en,
    input logic [7:0]  inv,
    input logic [15:0] max_m,
    input logic [15:0] min_m
  );
    settle();
    cfg_we <= 1'b1;
    cfg_index <= esq_pkg::REG_ENABLE_MASK;
    cfg_wdata <= {8'h00, en};
    @(posedge clk);
    cfg_index <= esq_pkg::REG_INVERT_MASK;
    cfg_wdata <= {8'h00, inv};
    @(posedge clk);
    cfg_index <= esq_pkg::REG_MAX_MAP;
    cfg_wdata <= max_m;
    @(posedge clk);
    cfg_index <= esq_pkg::REG_MIN_MAP;
    cfg_wdata <= min_m;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // mostly real switches, sometimes none or a switch that does not exist
  function automatic logic [15:0] random_map();
    logic [15:0] m;
    for (int p = 0; p < 4; p++)
      m[p*4 +: 4] = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 7))
                                                : 4'($urandom_range(8, 15));
    return m;
  endfunction

  task automatic random_phase(input int count);
    logic       cmd;
    logic [1:0] esel;
    int         roll;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 9) < 7) ? esq_pkg::CMD_EVENT : esq_pkg::CMD_QUERY;
      // slow moving tick so releases land both before and after deadlines
      roll = $urandom_range(0, 19);
      if (roll == 0)
        clock_ms = $urandom();
      else if (roll == 1)
        clock_ms = 32'hffff_fff0 + $urandom_range(0, 15);
      else
        clock_ms = clock_ms + $urandom_range(0, 3);
      esel = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                         : 2'($urandom_range(0, 1));
      put_request(cmd, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), clock_ms,
                  esel, 8'($urandom_range(0, 255)));
    end
  endtask

  // result side
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        hold_done <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = $urandom_range(0, take_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // register defaults: everything disabled, no switches mapped
    put_request(esq_pkg::CMD_EVENT, 3'd3, 2'd1, 1'b0, 1'b1, 32'd10, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd0, 1'b0, 1'b0, 32'd11, esq_pkg::END_MIN, 8'hff);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd3, 1'b0, 1'b0, 32'd11, esq_pkg::END_MAX, 8'h00);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd1, 1'b0, 1'b0, 32'd12, 2'd2, 8'h00);

    // low four switches active low; stepper 2 max is a missing switch,
    // stepper 3 has no max and a missing min
    set_config(8'hff, 8'h0f, 16'hf854, 16'hef10);
    put_request(esq_pkg::CMD_EVENT, 3'd4, 2'd0, 1'b1, 1'b1, 32'd100, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd4, 2'd0, 1'b1, 1'b1, 32'd101, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd4, 2'd0, 1'b0, 1'b1, 32'd103, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd4, 2'd0, 1'b0, 1'b1, 32'd105, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd4, 2'd0, 1'b0, 1'b1, 32'd106, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd4, 2'd0, 1'b1, 1'b1, 32'd200, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd0, 2'd0, 1'b0, 1'b1, 32'd201, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd1, 2'd3, 1'b0, 1'b1, 32'd202, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd5, 2'd1, 1'b1, 1'b0, 32'd203, esq_pkg::END_MIN, 8'h00);
    // deadline wraps past zero, so the next release clears at once
    put_request(esq_pkg::CMD_EVENT, 3'd6, 2'd2, 1'b1, 1'b1, 32'hffff_fffe,
                esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd6, 2'd2, 1'b0, 1'b1, 32'hffff_ffff,
                esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_EVENT, 3'd6, 2'd2, 1'b1, 1'b0, 32'd0, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd0, 1'b0, 1'b0, 32'd300, esq_pkg::END_MAX, 8'h10);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd0, 1'b0, 1'b0, 32'd300, esq_pkg::END_MIN, 8'hff);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd0, 1'b0, 1'b0, 32'd300, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd2, 1'b0, 1'b0, 32'd301, esq_pkg::END_MAX, 8'hff);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd2, 1'b0, 1'b0, 32'd301, esq_pkg::END_MIN, 8'hff);
    put_request(esq_pkg::CMD_QUERY, 3'd0, 2'd3, 1'b0, 1'b0, 32'd302, esq_pkg::END_MIN, 8'h00);
    put_request(esq_pkg::CMD_QUERY, 3'd7, 2'd3, 1'b1, 1'b1, 32'hffff_ffff, 2'd3, 8'hff);
    put_request(esq_pkg::CMD_EVENT, 3'd7, 2'd3, 1'b1, 1'b1, 32'hffff_ffff, 2'd3, 8'hff);

    set_config(8'hff, 8'h00, 16'h3210, 16'h7654);
    random_phase(100);

    // sender never idles while the result side holds off for a while
    set_config(8'hff, 8'hff, random_map(), random_map());
    send_gap_max = 0;
    hold_request <= 1'b1;
    random_phase(100);
    send_gap_max = 7;

    set_config(8'h00, 8'hff, 16'hffff, 16'hffff);
    random_phase(30);

    set_config(8'($urandom_range(1, 255)), 8'($urandom()), random_map(), random_map());
    send_gap_max = 0;
    take_gap_max = 0;
    random_phase(110);
    send_gap_max = 7;
    take_gap_max = 7;

    set_config(8'hff, 8'h55, 16'h0000, 16'hffff);
    random_phase(100);

    set_config(8'($urandom_range(1, 255)), 8'($urandom()), random_map(), random_map());
    random_phase(100);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d switch events and %0d end stop queries over %0d register settings",
             n_events, n_queries, n_settings);
    $display("%0d results compared, %0d wrong or unexpected", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/esq_pkg.sv
rtl/esq_ram.sv
rtl/end_stop_event_qualifier_core.sv
test/esq_result_checker.sv
test/end_stop_event_qualifier_core_test.sv
